>>> design/bounded_ordered_list_store_unit_defines.svh
// assertion helpers for the ordered list store
`ifndef BOUNDED_ORDERED_LIST_STORE_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_STORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BOLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BOLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bols_pkg.sv
`default_nettype none
package bols_pkg;

    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 7;

    typedef logic [CMD_W-1:0]        t_cmd;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [ST_W-1:0]         t_status;
    typedef logic [LEN_W-1:0]        t_len;

    // command codes
    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_BACK  = 3'd1;
    localparam t_cmd CMD_SEARCH    = 3'd2;
    localparam t_cmd CMD_DELETE    = 3'd3;
    localparam t_cmd CMD_CLEAR     = 3'd4;

    // status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // controller to datapath strobes
    typedef struct packed {
        logic capture;
        logic exec;
        logic report;
    } t_dp_cmd;

    // datapath occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> design/bols_in_if.sv
`default_nettype none
interface bols_in_if;
    logic              valid;
    logic              ready;
    bols_pkg::t_cmd    command;
    bols_pkg::t_val    value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

>>> design/bols_out_if.sv
`default_nettype none
interface bols_out_if;
    logic              valid;
    logic              ready;
    bols_pkg::t_status status;
    logic              found;
    bols_pkg::t_len    length;
    bols_pkg::t_val    front_value;
    bols_pkg::t_val    back_value;

    modport source (output valid, output status, output found, output length,
                    output front_value, output back_value, input ready);
    modport sink   (input valid, input status, input found, input length,
                    input front_value, input back_value, output ready);
endinterface
`default_nettype wire

>>> design/bols_ctl.sv
`default_nettype none
module bols_ctl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bols_pkg::t_dp_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_pend, n_pend;
    logic r_ovld, n_ovld;
    logic slot_free;
    logic accept;
    logic report;

    // output slot is free when empty or being drained this cycle
    assign slot_free  = !r_ovld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (!r_pend || slot_free);
    assign accept     = i_in_valid && o_in_ready;
    assign report     = (r_state == S_IDLE) && r_pend && slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        if (r_state == S_EXEC) begin
            n_pend = 1'b1;
        end else if (report) begin
            n_pend = 1'b0;
        end
    end

    always_comb begin
        n_ovld = r_ovld;
        if (report) begin
            n_ovld = 1'b1;
        end else if (i_out_ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_ovld  <= n_ovld;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.report  = report;

endmodule
`default_nettype wire

>>> design/bols_dp.sv
`default_nettype none
module bols_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bols_pkg::t_dp_cmd                 i_cmd,
    input  wire bols_pkg::t_cmd                    i_command,
    input  wire bols_pkg::t_val                    i_value,
    output bols_pkg::t_status                      o_status,
    output logic                                   o_found,
    output bols_pkg::t_len                         o_length,
    output bols_pkg::t_val                         o_front_value,
    output bols_pkg::t_val                         o_back_value,
    output bols_pkg::t_dp_sts                      o_sts,
    output logic [$clog2(CAPACITY + 1)-1:0]        o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    bols_pkg::t_val     r_cell [CAPACITY];
    bols_pkg::t_val     n_cell [CAPACITY];
    logic [CAPACITY-1:0] r_vld, n_vld;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    bols_pkg::t_cmd     r_cmd;
    bols_pkg::t_val     r_val;
    logic [CAPACITY-1:0] r_match, n_match;
    bols_pkg::t_status  r_status, n_status;
    logic               r_found, n_found;

    bols_pkg::t_status  r_o_status;
    logic               r_o_found;
    bols_pkg::t_len     r_o_len;
    bols_pkg::t_val     r_o_front, r_o_back;

    logic                full, empty, hit_any;
    logic [CAPACITY-1:0] below_hit;
    logic [CAPACITY-1:0] vld_up, vld_down, wr_tail, last;
    logic                do_front, do_back, do_del, do_clr;
    bols_pkg::t_val      back_val;

    assign full     = r_vld[CAPACITY-1];
    assign empty    = !r_vld[0];
    assign hit_any  = |r_match;
    // cells strictly below the first match
    assign below_hit = ~r_match & (r_match - CAPACITY'(1));
    assign vld_up    = {r_vld[CAPACITY-2:0], 1'b1};
    assign vld_down  = {1'b0, r_vld[CAPACITY-1:1]};
    assign wr_tail   = ~r_vld & vld_up;
    assign last      = r_vld & ~vld_down;

    // compare the incoming value against every occupied cell
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_match[i] = r_vld[i] && (r_cell[i] == i_value);
        end
    end

    always_comb begin
        do_front = 1'b0;
        do_back  = 1'b0;
        do_del   = 1'b0;
        do_clr   = 1'b0;
        n_status = bols_pkg::ST_OK;
        n_found  = 1'b0;
        case (r_cmd)
            bols_pkg::CMD_INS_FRONT: begin
                do_front = !full;
                n_status = full ? bols_pkg::ST_FULL : bols_pkg::ST_OK;
            end
            bols_pkg::CMD_INS_BACK: begin
                do_back  = !full;
                n_status = full ? bols_pkg::ST_FULL : bols_pkg::ST_OK;
            end
            bols_pkg::CMD_SEARCH, bols_pkg::CMD_DELETE: begin
                if (empty) begin
                    n_status = bols_pkg::ST_EMPTY;
                end else if (!hit_any) begin
                    n_status = bols_pkg::ST_NOT_FOUND;
                end else begin
                    n_found = 1'b1;
                    do_del  = (r_cmd == bols_pkg::CMD_DELETE);
                end
            end
            bols_pkg::CMD_CLEAR: begin
                do_clr = 1'b1;
            end
            default: begin
                n_status = bols_pkg::ST_OK;
            end
        endcase
    end

    // per-cell next value: shift down, shift up, or tail write
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bols_pkg::t_val prev_val;
        bols_pkg::t_val next_val;
        if (g == 0) begin : g_head
            assign prev_val = r_val;
        end else begin : g_body
            assign prev_val = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign next_val = r_cell[g];
        end else begin : g_mid
            assign next_val = r_cell[g+1];
        end
        always_comb begin
            n_cell[g] = r_cell[g];
            if (do_front) begin
                n_cell[g] = prev_val;
            end else if (do_back && wr_tail[g]) begin
                n_cell[g] = r_val;
            end else if (do_del && !below_hit[g]) begin
                n_cell[g] = next_val;
            end
        end
    end

    always_comb begin
        n_vld = r_vld;
        n_cnt = r_cnt;
        if (i_cmd.exec) begin
            if (do_front || do_back) begin
                n_vld = vld_up;
                n_cnt = r_cnt + CNT_W'(1);
            end else if (do_del) begin
                n_vld = vld_down;
                n_cnt = r_cnt - CNT_W'(1);
            end else if (do_clr) begin
                n_vld = '0;
                n_cnt = '0;
            end
        end
    end

    // one-hot select of the last occupied cell
    always_comb begin
        back_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            back_val = back_val | ({bols_pkg::VAL_W{last[i]}} & r_cell[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else begin
            r_vld <= n_vld;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cell[i] <= n_cell[i];
            end
            r_status <= n_status;
            r_found  <= n_found;
        end
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_val   <= i_value;
            r_match <= n_match;
        end
        if (i_cmd.report) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_len    <= bols_pkg::LEN_W'(r_cnt);
            r_o_front  <= r_vld[0] ? r_cell[0] : '0;
            r_o_back   <= back_val;
        end
    end

    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_length      = r_o_len;
    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_sts.full    = full;
    assign o_sts.empty   = empty;
    assign o_count       = r_cnt;

endmodule
`default_nettype wire

>>> design/bounded_ordered_list_store_unit.sv
// ordered list store: up to CAPACITY signed 32-bit entries, front to back
// request channel i_req carries command and value, valid/ready handshake;
//   commands: insert front, insert back, search, delete first match, clear
// response channel o_rsp carries status, found, length, front and back value;
//   exactly one response per request, in request order
// one request in flight at a time; the capture step latches the request and
//   compares the value against all cells at once, the execute state shifts
//   the cell array and updates occupancy, and the response register is
//   loaded while the next request is taken
// the response register decouples the sides: a new request is taken while a
//   finished response waits; if a second result is ready and the receiver
//   still stalls, ready drops until the waiting response is taken
// reset (synchronous, active low) empties the list and drops the response valid;
//   cell contents are not cleared, only occupancy is
// unknown command codes leave the list unchanged and report ok
`default_nettype none
`include "bounded_ordered_list_store_unit_defines.svh"
module bounded_ordered_list_store_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bols_in_if.sink     i_req,
    bols_out_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    bols_pkg::t_dp_cmd  dp_cmd;
    bols_pkg::t_dp_sts  dp_sts;
    logic [CNT_W-1:0]   dp_count;
    logic               in_ready;
    logic               out_valid;

    // sequencing and handshakes
    bols_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd)
    );

    // cell array, match vector and response register
    bols_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_command     (i_req.command),
        .i_value       (i_req.value),
        .o_status      (o_rsp.status),
        .o_found       (o_rsp.found),
        .o_length      (o_rsp.length),
        .o_front_value (o_rsp.front_value),
        .o_back_value  (o_rsp.back_value),
        .o_sts         (dp_sts),
        .o_count       (dp_count)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // one request in flight: no request is taken right after another
    `BOLS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request taken back to back")
    // occupancy flags agree with the entry count
    `BOLS_ASSERT_NOW(a_fill_flags, i_clk, i_rst_n, 1'b1, (dp_sts.full == (dp_count == CNT_W'(CAPACITY))) && (dp_sts.empty == (dp_count == '0)), "occupancy flags disagree with count")
    // a stalled response stays valid until it is taken
    `BOLS_ASSERT_NEXT(a_rsp_held, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, o_rsp.valid, "response dropped before it was taken")

endmodule
`default_nettype wire
